### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MFA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("mfa check failed");
`define MFA_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("mfa check failed");
`else
`define MFA_ASSERT(lbl, clk, rst_n, prop)
`define MFA_ASSERT_NR(lbl, clk, prop)
`endif

`endif

### rtl/mfa_pkg.sv
package mfa_pkg;
	localparam int LIMB_W = 64;
	localparam int LIMBS  = 4;
	localparam int ELEM_W = LIMB_W * LIMBS;
	// accumulator for product plus reduction terms, always below 2^514
	localparam int TW     = 514;
	localparam int ROUNDS = 4;
	localparam int RND_ST = 5;
	localparam int PRD_ST = 5;
	localparam int NST    = PRD_ST + ROUNDS * RND_ST + 1;

	localparam logic [ELEM_W-1:0] Q_MOD =
		256'h73eda753299d7d483339d80809a1d80553bda402fffe5bfeffffffff00000001;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_NEG = 2'd2,
		OP_MUL = 2'd3
	} op_t;
endpackage

### rtl/mfa_mul64.sv
// 64x64 multiply from four 32x32 products, two register stages
module mfa_mul64 (
	input  logic         clk,
	input  logic         en1,
	input  logic         en2,
	input  logic [63:0]  x,
	input  logic [63:0]  y,
	output logic [127:0] p
);
	logic [63:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] p_s2;

	always_ff @(posedge clk) begin
		if (en1) begin
			ll_s1 <= 64'(x[31:0]) * 64'(y[31:0]);
			lh_s1 <= 64'(x[31:0]) * 64'(y[63:32]);
			hl_s1 <= 64'(x[63:32]) * 64'(y[31:0]);
			hh_s1 <= 64'(x[63:32]) * 64'(y[63:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= {64'd0, ll_s1} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
				+ {hh_s1, 64'd0};
		end
	end

	assign p = p_s2;
endmodule

### rtl/mfa_addsub.sv
// add / subtract / negate path, two stages
module mfa_addsub (
	input  logic                      clk,
	input  logic [1:0]                en,
	input  mfa_pkg::op_t              op_in,
	input  logic [mfa_pkg::ELEM_W-1:0] a,
	input  logic [mfa_pkg::ELEM_W-1:0] b,
	output mfa_pkg::op_t              op_out,
	output logic [mfa_pkg::ELEM_W-1:0] alt_out
);
	import mfa_pkg::*;

	op_t               op_s1, op_s2;
	logic [ELEM_W:0]   s_s1, d_s1;
	logic [ELEM_W-1:0] n_s1, alt_s2, alt_c;
	logic [ELEM_W+1:0] sq;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= op_in;
			s_s1  <= {1'b0, a} + {1'b0, b};
			d_s1  <= {1'b0, a} - {1'b0, b};
			n_s1  <= (a != '0) ? Q_MOD - a : '0;
		end
	end

	assign sq = {1'b0, s_s1} - {2'b0, Q_MOD};

	always_comb begin
		case (op_s1)
			OP_ADD: alt_c = sq[ELEM_W+1] ? s_s1[ELEM_W-1:0] : sq[ELEM_W-1:0];
			OP_SUB: alt_c = d_s1[ELEM_W] ? d_s1[ELEM_W-1:0] + Q_MOD : d_s1[ELEM_W-1:0];
			OP_NEG: alt_c = n_s1;
			OP_MUL: alt_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s2  <= op_s1;
			alt_s2 <= alt_c;
		end
	end

	assign op_out  = op_s2;
	assign alt_out = alt_s2;
endmodule

### rtl/mfa_prod.sv
// full 512-bit product a*b: multipliers, row sums, pair sums, final sum
module mfa_prod (
	input  logic                       clk,
	input  logic [mfa_pkg::PRD_ST-1:0]  en,
	input  logic [mfa_pkg::ELEM_W-1:0]  a,
	input  logic [mfa_pkg::ELEM_W-1:0]  b,
	output logic [mfa_pkg::TW-1:0]      t
);
	import mfa_pkg::*;

	logic [2*LIMB_W-1:0]      pp [LIMBS][LIMBS];
	logic [ELEM_W-1:0]        lo_v [LIMBS];
	logic [ELEM_W-1:0]        hi_v [LIMBS];
	logic [ELEM_W+LIMB_W-1:0] row_s3 [LIMBS];
	logic [ELEM_W+2*LIMB_W-1:0] pr_s4 [2];
	logic [TW-1:0]            t_s5;

	for (genvar i = 0; i < LIMBS; i++) begin : g_row
		for (genvar j = 0; j < LIMBS; j++) begin : g_col
			mfa_mul64 u_mul (
				.clk(clk), .en1(en[0]), .en2(en[1]),
				.x(a[LIMB_W*j +: LIMB_W]), .y(b[LIMB_W*i +: LIMB_W]),
				.p(pp[i][j])
			);
			assign lo_v[i][LIMB_W*j +: LIMB_W] = pp[i][j][LIMB_W-1:0];
			assign hi_v[i][LIMB_W*j +: LIMB_W] = pp[i][j][2*LIMB_W-1:LIMB_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < LIMBS; i++) begin
				row_s3[i] <= {{LIMB_W{1'b0}}, lo_v[i]} + {hi_v[i], {LIMB_W{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pr_s4[0] <= {{LIMB_W{1'b0}}, row_s3[0]} + {row_s3[1], {LIMB_W{1'b0}}};
			pr_s4[1] <= {{LIMB_W{1'b0}}, row_s3[2]} + {row_s3[3], {LIMB_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s5 <= TW'({{2*LIMB_W{1'b0}}, pr_s4[0]}) + TW'({pr_s4[1], {2*LIMB_W{1'b0}}});
		end
	end

	assign t = t_s5;
endmodule

### rtl/mfa_round.sv
// one Montgomery reduction round: t += m*q << 64*IDX, m chosen to clear limb IDX
module mfa_round #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic [mfa_pkg::RND_ST-1:0]  en,
	input  logic [mfa_pkg::TW-1:0]      t_in,
	output logic [mfa_pkg::TW-1:0]      t_out
);
	import mfa_pkg::*;

	localparam int SH = LIMB_W * IDX;

	logic [LIMB_W-1:0]        x, m;
	logic [LIMB_W-1:0]        m_s1;
	logic [TW-1:0]            t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [2*LIMB_W-1:0]      pp [LIMBS];
	logic [ELEM_W-1:0]        lo_v, hi_v;
	logic [ELEM_W+LIMB_W-1:0] row_s4;

	// -q^-1 mod 2^64 is -(2^32+1), so m = -(x + x<<32)
	assign x = t_in[SH +: LIMB_W];
	assign m = LIMB_W'(0) - (x + {x[31:0], 32'd0});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_s1 <= m;
			t_s1 <= t_in;
		end
	end

	for (genvar j = 0; j < LIMBS; j++) begin : g_mul
		mfa_mul64 u_mul (
			.clk(clk), .en1(en[1]), .en2(en[2]),
			.x(m_s1), .y(Q_MOD[LIMB_W*j +: LIMB_W]), .p(pp[j])
		);
		assign lo_v[LIMB_W*j +: LIMB_W] = pp[j][LIMB_W-1:0];
		assign hi_v[LIMB_W*j +: LIMB_W] = pp[j][2*LIMB_W-1:LIMB_W];
	end

	always_ff @(posedge clk) begin
		if (en[1]) t_s2 <= t_s1;
		if (en[2]) t_s3 <= t_s2;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			row_s4 <= {{LIMB_W{1'b0}}, lo_v} + {hi_v, {LIMB_W{1'b0}}};
			t_s4   <= t_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s5 <= t_s4 + (TW'(row_s4) << SH);
		end
	end

	assign t_out = t_s5;
endmodule

### rtl/mfa_final.sv
// final conditional subtract of q and result select
module mfa_final (
	input  logic                       clk,
	input  logic                       en,
	input  mfa_pkg::op_t               op_in,
	input  logic [mfa_pkg::ELEM_W-1:0] alt_in,
	input  logic [mfa_pkg::TW-1:0]     t_in,
	output logic [mfa_pkg::ELEM_W-1:0] r_out
);
	import mfa_pkg::*;

	logic [TW-ELEM_W-1:0] t;
	logic [TW-ELEM_W:0]   dq;
	logic [ELEM_W-1:0]    r, r_s1;

	assign t  = t_in[TW-1:ELEM_W];
	assign dq = {1'b0, t} - (TW-ELEM_W+1)'(Q_MOD);
	assign r  = dq[TW-ELEM_W] ? t[ELEM_W-1:0] : dq[ELEM_W-1:0];

	always_ff @(posedge clk) begin
		if (en) r_s1 <= (op_in == OP_MUL) ? r : alt_in;
	end

	assign r_out = r_s1;
endmodule

### rtl/montgomery_field_alu_top.sv
// Field ALU modulo the 255-bit prime q, operands and results in Montgomery form.
// Input stream: s_tuser carries the operation (add, subtract, negate a,
// Montgomery multiply), s_tdata carries operands a and b, four 64-bit limbs each.
// Output stream: one 256-bit reduced result per request on m_tdata.
// Pipeline: 26 register stages (5 product stages, 4 reduction rounds of 5 stages
// each, 1 final subtract/select stage that is also the output register). Add,
// subtract and negate ride the same pipeline, so results leave in request order.
// Throughput: one request per cycle while not stalled; the 64x64 multipliers
// are split into 32x32 products with a register stage after each multiply.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled receiver lets bubbles close up; s_tready drops only once every stage
// holds a request. Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits; the pipeline is empty afterward.
module montgomery_field_alu_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [511:0] s_tdata,  // a_limb0, a_limb1, a_limb2, a_limb3, b_limb0..b_limb3
	input  logic [1:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata   // r_limb0, r_limb1, r_limb2, r_limb3
);
	import mfa_pkg::*;

	`include "assert_macros.svh"

	localparam int DL_LO = 2;
	localparam int DL_HI = NST - 2;

	logic [NST-1:0]    vld_q;
	logic [NST-1:0]    en;
	logic [ELEM_W-1:0] a, b;
	op_t               op_as;
	logic [ELEM_W-1:0] alt_as;
	logic [TW-1:0]     tr [ROUNDS+1];
	op_t               op_dl_q  [DL_LO:DL_HI];
	logic [ELEM_W-1:0] alt_dl_q [DL_LO:DL_HI];

	assign a = s_tdata[ELEM_W-1:0];
	assign b = s_tdata[2*ELEM_W-1:ELEM_W];

	// per-stage advance: empty, or the next stage moves
	assign en[NST-1] = !vld_q[NST-1] || m_tready;
	for (genvar k = 0; k < NST-1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) vld_q[k] <= (k == 0) ? s_tvalid : vld_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NST-1];

	mfa_addsub u_addsub (
		.clk(clk), .en(en[1:0]), .op_in(op_t'(s_tuser)), .a(a), .b(b),
		.op_out(op_as), .alt_out(alt_as)
	);

	mfa_prod u_prod (
		.clk(clk), .en(en[PRD_ST-1:0]), .a(a), .b(b), .t(tr[0])
	);

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		mfa_round #(.IDX(r)) u_round (
			.clk(clk), .en(en[PRD_ST+RND_ST*r +: RND_ST]),
			.t_in(tr[r]), .t_out(tr[r+1])
		);
	end

	// op and add/sub result travel alongside the multiply stages
	for (genvar k = DL_LO; k <= DL_HI; k++) begin : g_dl
		if (k == DL_LO) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					op_dl_q[k]  <= op_as;
					alt_dl_q[k] <= alt_as;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					op_dl_q[k]  <= op_dl_q[k-1];
					alt_dl_q[k] <= alt_dl_q[k-1];
				end
			end
		end
	end

	mfa_final u_final (
		.clk(clk), .en(en[NST-1]), .op_in(op_dl_q[DL_HI]), .alt_in(alt_dl_q[DL_HI]),
		.t_in(tr[ROUNDS]), .r_out(m_tdata)
	);

	`MFA_ASSERT(a_empty_ready, clk, arst_n, !m_tvalid |-> s_tready)
	`MFA_ASSERT(a_fill, clk, arst_n, (s_tvalid && s_tready) |=> vld_q[0])
	`MFA_ASSERT(a_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	`MFA_ASSERT_NR(a_rst_empty, clk, !arst_n |-> !m_tvalid)
endmodule
